// ===== sv/skst_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key set table package
// Shared sizes, command and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package skst_pkg;

	// Number of key cells in the chain.
	localparam int CAPACITY = 16;
	// Width of one stored key.
	localparam int KEY_W = 32;
	// Width of a count or index that can also hold CAPACITY itself.
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Request commands; the unused code behaves as a search.
	typedef enum logic [1:0] {
		CMD_SEARCH = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_UNUSED = 2'd3
	} skst_cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} skst_status_t;

	// Sequencer states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_BUSY = 1'b1
	} skst_state_t;

	// Control broadcast to every cell for one cycle.
	typedef struct packed {
		logic ins;
		logic del;
	} skst_ctl_t;

endpackage

// ===== sv/skst_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key set table cell
// Holds one key, compares it against the request key, and shifts toward
// or away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skst_cell (
	input  logic                        clk,
	input  skst_pkg::skst_ctl_t         ctl,
	input  logic [skst_pkg::KEY_W-1:0]  req_key,
	input  logic                        occ,
	input  logic                        left_less,
	input  logic [skst_pkg::KEY_W-1:0]  left_key,
	input  logic [skst_pkg::KEY_W-1:0]  right_key,
	output logic [skst_pkg::KEY_W-1:0]  stored_key,
	output logic                        less,
	output logic                        eq
);
	import skst_pkg::*;

	logic [KEY_W-1:0] stored_q;

	// Signed order against the request key; empty cells never match.
	assign less = occ && ($signed(stored_q) < $signed(req_key));
	assign eq   = occ && (stored_q == req_key);
	assign stored_key = stored_q;

	// Cells below the insertion point keep their key; the first cell not
	// less than the key takes it, the rest take their left neighbor's key.
	// On delete every cell from the match upward takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins && !less) begin
			stored_q <= left_less ? req_key : left_key;
		end else if (ctl.del && !less) begin
			stored_q <= right_key;
		end
	end

endmodule

// ===== sv/sorted_key_set_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key set table
// A set of distinct signed keys kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ group: cmd (search, insert, delete) and a signed
// key. Each request gives exactly one result on the m_ group: found, status,
// the position of the first stored key not less than the key (taken before
// any change), and the number of keys stored afterward.
// One request is in work at a time: the request is registered first, and
// then every cell compares its key with the request key at once and the
// whole chain shifts in one step when the request is committed.
// A new request is taken only after the last one has been committed.
// The result sits in an output register, so the next request is accepted
// while a result still waits; if that result is still not taken when the
// next one is ready, the block holds until the receiver takes it.
// Reset empties the table; key cells hold no defined value until written.
// An insert into a full table is refused with the full status.
// ----------------------------------------------------------------------------
module sorted_key_set_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] cmd, [33:2] key, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] found, [2:1] status, [7:3] position,
	                               // [12:8] stored_count, [15:13] zero
);
	import skst_pkg::*;

	skst_state_t      state_q, state_d;
	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             m_tvalid_q;
	logic [12:0]      res_q;

	logic                 accept;
	logic                 commit;
	logic [CAPACITY-1:0]  less, eq, first, occ;
	logic [KEY_W-1:0]     cell_key [CAPACITY];
	logic                 hit, full;
	logic [CNT_W-1:0]     pos, pos_or;
	skst_status_t         status;
	skst_ctl_t            ctl;

	// Handshake.
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q};

	// Sequencer: take a request, then commit it once the output is free.
	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_BUSY;
			end
			S_BUSY: begin
				if (!m_tvalid_q || m_tready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tdata[1:0];
			key_q <= s_tdata[KEY_W+1:2];
		end
	end

	// Chain of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             l_less;
		logic [KEY_W-1:0] l_key, r_key;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign l_less = 1'b0;
			assign l_key  = key_q;
		end else begin : g_mid
			assign l_less = less[i-1];
			assign l_key  = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_key = cell_key[i];
		end else begin : g_inner
			assign r_key = cell_key[i+1];
		end

		assign first[i] = !less[i] && !l_less ? (i == 0) : !less[i] && l_less;

		skst_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.req_key    (key_q),
			.occ        (occ[i]),
			.left_less  (l_less),
			.left_key   (l_key),
			.right_key  (r_key),
			.stored_key (cell_key[i]),
			.less       (less[i]),
			.eq         (eq[i])
		);
	end

	// Position: index of the single boundary cell, or CAPACITY if every
	// cell holds a smaller key.
	always_comb begin
		pos_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) pos_or = pos_or | CNT_W'(i);
		end
		pos = (|first) ? pos_or : CNT_W'(CAPACITY);
	end

	assign hit  = |eq;
	assign full = (count_q == CNT_W'(CAPACITY));

	// Decide the change to the table and the result status.
	always_comb begin
		ctl     = '0;
		count_d = count_q;
		status  = ST_OK;
		case (cmd_q)
			CMD_INSERT: begin
				if (hit) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins = commit;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (!hit) begin
					status = ST_MISSING;
				end else begin
					ctl.del = commit;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Key count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= {count_d, pos, status, hit};
		end
	end

endmodule
